>>> src/multichannel_pulse_period_speed_top_assert.svh
// Assertion macros for the tachometer top level.
`ifndef MULTICHANNEL_PULSE_PERIOD_SPEED_TOP_ASSERT_SVH
`define MULTICHANNEL_PULSE_PERIOD_SPEED_TOP_ASSERT_SVH

// Check a property on the rising clock edge while out of reset.
`define MPPS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define MPPS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/mpps_pkg.sv
// Shared widths, register codes and reset values for the tachometer.
package mpps_pkg;

    localparam int NUM_CHANNELS_DEF = 4;

    localparam int CHAN_W    = 2;
    localparam int COUNT_W   = 16;
    localparam int PERIOD_W  = 17;
    localparam int TIMEOUT_W = 16;
    localparam int NUMER_W   = 32;
    localparam int SPEED_W   = 24;
    localparam int DIVW      = 32;
    localparam int PROD_W    = COUNT_W + PERIOD_W;
    localparam int TICKS_W   = PROD_W + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUMER   = 2'd2;

    localparam logic [PERIOD_W-1:0]  PERIOD_RST  = 17'd900;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd40000;
    localparam logic [NUMER_W-1:0]   NUMER_RST   = 32'd448369091;

    localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

endpackage

>>> src/mpps_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, saturated to the speed width.
module mpps_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [mpps_pkg::DIVW-1:0]         dividend,
    input  logic [mpps_pkg::DIVW-1:0]         divisor,
    output logic                              done,
    output logic [mpps_pkg::SPEED_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(mpps_pkg::DIVW + 1);

    logic [mpps_pkg::DIVW-1:0] rem_reg, rem_next;
    logic [mpps_pkg::DIVW-1:0] quo_reg, quo_next;
    logic [mpps_pkg::DIVW-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      done_reg, done_next;
    logic [mpps_pkg::DIVW:0]   shifted;
    logic                      fits;

    assign shifted = {rem_reg, quo_reg[mpps_pkg::DIVW-1]};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = CNT_W'(mpps_pkg::DIVW);
        end else if (cnt_reg != '0) begin
            if (fits) begin
                rem_next = mpps_pkg::DIVW'(shifted - {1'b0, dvs_reg});
            end else begin
                rem_next = shifted[mpps_pkg::DIVW-1:0];
            end
            quo_next  = {quo_reg[mpps_pkg::DIVW-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = (quo_reg[mpps_pkg::DIVW-1:mpps_pkg::SPEED_W] != '0)
                    ? mpps_pkg::SPEED_MAX : quo_reg[mpps_pkg::SPEED_W-1:0];

endmodule

>>> src/multichannel_pulse_period_speed_top.sv
// Top level of the multichannel input-capture tachometer with timeout.
// Each input word is a capture edge or an overflow tick for one channel; at most one
// result word follows. A tick or an arming capture is taken and the block is ready
// again on the next cycle; a timeout first loads its result through the emit state.
// A measuring capture passes a registered 16x17 multiply, an add/subtract state, then
// the 32-step bit-serial divider (skipped with the speed saturated for a zero or
// negative span), and an emit state that loads the result once the output register is free.
// The output register holds a finished word while the next input word is accepted.
// Configuration writes are taken at any time with cfg_ready held high.
`include "multichannel_pulse_period_speed_top_assert.svh"

module multichannel_pulse_period_speed_top #(
    parameter int NUM_CHANNELS = mpps_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // s_tdata: channel[1:0], capture_count[17:2], zero fill[23:18]
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [23:0]                          s_tdata,
    // s_tuser: operation[0]
    input  logic                                 s_tuser,
    // m_tdata: out_channel[1:0], speed[25:2], zero fill[31:26]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [31:0]                          m_tdata,
    // m_tuser: timed_out[0]
    output logic                                 m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mpps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mpps_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SUB  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0] state_reg, state_next;

    logic [mpps_pkg::PERIOD_W-1:0]  period_reg;
    logic [mpps_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [mpps_pkg::NUMER_W-1:0]   numer_reg;

    logic                          armed_reg [NUM_CHANNELS];
    logic [mpps_pkg::COUNT_W-1:0]  prev_reg  [NUM_CHANNELS];
    logic [mpps_pkg::COUNT_W-1:0]  ovf_reg   [NUM_CHANNELS];

    logic [mpps_pkg::CHAN_W-1:0]   wch_reg, wch_next;
    logic [mpps_pkg::COUNT_W-1:0]  wovf_reg, wovf_next;
    logic [mpps_pkg::COUNT_W-1:0]  wprev_reg, wprev_next;
    logic [mpps_pkg::COUNT_W-1:0]  wnow_reg, wnow_next;
    logic [mpps_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [mpps_pkg::SPEED_W-1:0]  rspeed_reg, rspeed_next;
    logic                          rtout_reg, rtout_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [mpps_pkg::CHAN_W-1:0]   m_chan_reg, m_chan_next;
    logic [mpps_pkg::SPEED_W-1:0]  m_speed_reg, m_speed_next;
    logic                          m_tout_reg, m_tout_next;

    logic                          in_op;
    logic [mpps_pkg::CHAN_W-1:0]   in_chan;
    logic [mpps_pkg::COUNT_W-1:0]  in_count;
    logic                          in_take;
    logic                          ch_ok;
    logic [CH_IDX_W-1:0]           ch_idx;
    logic                          ch_armed;
    logic [mpps_pkg::COUNT_W-1:0]  ovf_inc;
    logic                          hit_timeout;
    logic                          out_free;

    logic [mpps_pkg::TICKS_W-1:0]  ticks;
    logic                          ticks_bad;
    logic                          div_start;
    logic                          div_done;
    logic [mpps_pkg::SPEED_W-1:0]  div_quo;

    assign in_op    = s_tuser;
    assign in_chan  = s_tdata[1:0];
    assign in_count = s_tdata[17:2];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_take   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign ch_ok       = (int'(in_chan) < NUM_CHANNELS);
    assign ch_idx      = CH_IDX_W'(in_chan);
    assign ch_armed    = ch_ok && armed_reg[ch_idx];
    assign ovf_inc     = ovf_reg[ch_idx] + 1'b1;
    assign hit_timeout = (ovf_inc >= timeout_reg);

    assign ticks = {1'b0, prod_reg} + mpps_pkg::TICKS_W'(wnow_reg)
                 - mpps_pkg::TICKS_W'(wprev_reg);
    assign ticks_bad = ticks[mpps_pkg::TICKS_W-1] || (ticks == '0);
    assign div_start = (state_reg == ST_SUB) && !ticks_bad;

    mpps_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (numer_reg),
        .divisor  (ticks[mpps_pkg::DIVW-1:0]),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= mpps_pkg::PERIOD_RST;
            timeout_reg <= mpps_pkg::TIMEOUT_RST;
            numer_reg   <= mpps_pkg::NUMER_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                mpps_pkg::REG_PERIOD:  period_reg  <= cfg_data[mpps_pkg::PERIOD_W-1:0];
                mpps_pkg::REG_TIMEOUT: timeout_reg <= cfg_data[mpps_pkg::TIMEOUT_W-1:0];
                mpps_pkg::REG_NUMER:   numer_reg   <= cfg_data[mpps_pkg::NUMER_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                armed_reg[i] <= 1'b0;
            end
        end else if (in_take && ch_ok) begin
            if (in_op == mpps_pkg::OP_CAPTURE) begin
                armed_reg[ch_idx] <= 1'b1;
            end else if (ch_armed && hit_timeout) begin
                armed_reg[ch_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take && ch_ok) begin
            if (in_op == mpps_pkg::OP_CAPTURE) begin
                prev_reg[ch_idx] <= in_count;
                ovf_reg[ch_idx]  <= '0;
            end else if (ch_armed) begin
                ovf_reg[ch_idx]  <= hit_timeout ? '0 : ovf_inc;
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        wch_next      = wch_reg;
        wovf_next     = wovf_reg;
        wprev_next    = wprev_reg;
        wnow_next     = wnow_reg;
        prod_next     = prod_reg;
        rspeed_next   = rspeed_reg;
        rtout_next    = rtout_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_chan_next   = m_chan_reg;
        m_speed_next  = m_speed_reg;
        m_tout_next   = m_tout_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_take && ch_armed) begin
                    wch_next = in_chan;
                    if (in_op == mpps_pkg::OP_CAPTURE) begin
                        wovf_next  = ovf_reg[ch_idx];
                        wprev_next = prev_reg[ch_idx];
                        wnow_next  = in_count;
                        state_next = ST_MUL;
                    end else if (hit_timeout) begin
                        rspeed_next = '0;
                        rtout_next  = 1'b1;
                        state_next  = ST_EMIT;
                    end
                end
            end
            ST_MUL: begin
                prod_next  = mpps_pkg::PROD_W'(wovf_reg) * mpps_pkg::PROD_W'(period_reg);
                state_next = ST_SUB;
            end
            ST_SUB: begin
                rtout_next = 1'b0;
                if (ticks_bad) begin
                    rspeed_next = mpps_pkg::SPEED_MAX;
                    state_next  = ST_EMIT;
                end else begin
                    state_next  = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    rspeed_next = div_quo;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_chan_next   = wch_reg;
                    m_speed_next  = rspeed_reg;
                    m_tout_next   = rtout_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wch_reg     <= wch_next;
        wovf_reg    <= wovf_next;
        wprev_reg   <= wprev_next;
        wnow_reg    <= wnow_next;
        prod_reg    <= prod_next;
        rspeed_reg  <= rspeed_next;
        rtout_reg   <= rtout_next;
        m_chan_reg  <= m_chan_next;
        m_speed_reg <= m_speed_next;
        m_tout_reg  <= m_tout_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_speed_reg, m_chan_reg};
    assign m_tuser  = m_tout_reg;

    `MPPS_ASSERT(a_measure_starts, aclk, aresetn, in_take && ch_armed && (in_op == mpps_pkg::OP_CAPTURE) |=> state_reg == ST_MUL, "armed capture did not start a measurement")
    `MPPS_ASSERT(a_out_from_emit, aclk, aresetn, $rose(m_tvalid_reg) |-> $past(state_reg == ST_EMIT), "result word loaded outside emit")
    `MPPS_ASSERT(a_timeout_zero, aclk, aresetn, m_tvalid_reg && m_tout_reg |-> m_speed_reg == '0, "timeout word carries nonzero speed")
    `MPPS_ASSERT(a_div_in_state, aclk, aresetn, div_done |-> state_reg == ST_DIV, "divider finished outside divide state")

endmodule

>>> test/tacho_checker.sv
// Tachometer checker: predicts speed words from accepted inputs and compares results.
module tacho_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [23:0]                     s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [31:0]                     m_tdata,
    input  logic                            m_tuser,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [mpps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mpps_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              pending,
    output int                              errors,
    output int                              results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [mpps_pkg::CHAN_W-1:0]  chan;
        logic [mpps_pkg::SPEED_W-1:0] speed;
        logic                         timed_out;
    } speed_word_t;

    speed_word_t                    speed_due [$];
    logic                           armed [4];
    logic [mpps_pkg::COUNT_W-1:0]   last_capture [4];
    logic [mpps_pkg::COUNT_W-1:0]   overflows [4];
    logic [mpps_pkg::PERIOD_W-1:0]  period;
    logic [mpps_pkg::TIMEOUT_W-1:0] timeout_limit;
    logic [mpps_pkg::NUMER_W-1:0]   numer;
    int                             n_err;
    int                             n_res;

    function automatic logic [mpps_pkg::SPEED_W-1:0] measured_speed(
        input logic [1:0] ch, input logic [15:0] cnt);
        longint elapsed;
        longint quot;
        elapsed = longint'(overflows[ch]) * longint'(period) + longint'(cnt)
                - longint'(last_capture[ch]);
        if (elapsed <= 0) return mpps_pkg::SPEED_MAX;
        quot = longint'(numer) / elapsed;
        if (quot > longint'(mpps_pkg::SPEED_MAX)) return mpps_pkg::SPEED_MAX;
        return quot[mpps_pkg::SPEED_W-1:0];
    endfunction

    task automatic predict_event(input logic op, input logic [1:0] ch, input logic [15:0] cnt);
        speed_word_t w;
        if (op == mpps_pkg::OP_CAPTURE) begin
            if (armed[ch]) begin
                w.chan      = ch;
                w.speed     = measured_speed(ch, cnt);
                w.timed_out = 1'b0;
                speed_due.push_back(w);
            end
            armed[ch]        = 1'b1;
            last_capture[ch] = cnt;
            overflows[ch]    = '0;
        end else if (armed[ch]) begin
            overflows[ch] = overflows[ch] + 1'b1;
            if (overflows[ch] >= timeout_limit) begin
                overflows[ch] = '0;
                armed[ch]     = 1'b0;
                w.chan        = ch;
                w.speed       = '0;
                w.timed_out   = 1'b1;
                speed_due.push_back(w);
            end
        end
    endtask

    task automatic check_word();
        speed_word_t want;
        speed_word_t got;
        got.chan      = m_tdata[1:0];
        got.speed     = m_tdata[25:2];
        got.timed_out = m_tuser;
        n_res++;
        if (speed_due.size() == 0) begin
            $display("%0t: unexpected word: ch %0d speed %0h timeout %0b",
                     $time, got.chan, got.speed, got.timed_out);
            n_err++;
        end else begin
            want = speed_due.pop_front();
            if (want !== got) begin
                $display("%0t: mismatch: expected ch %0d speed %0h timeout %0b,",
                         $time, want.chan, want.speed, want.timed_out,
                         " got ch %0d speed %0h timeout %0b",
                         got.chan, got.speed, got.timed_out);
                n_err++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                armed[i]        = 1'b0;
                last_capture[i] = '0;
                overflows[i]    = '0;
            end
            period        = mpps_pkg::PERIOD_RST;
            timeout_limit = mpps_pkg::TIMEOUT_RST;
            numer         = mpps_pkg::NUMER_RST;
            speed_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    mpps_pkg::REG_PERIOD:  period        = cfg_data[mpps_pkg::PERIOD_W-1:0];
                    mpps_pkg::REG_TIMEOUT: timeout_limit = cfg_data[mpps_pkg::TIMEOUT_W-1:0];
                    mpps_pkg::REG_NUMER:   numer         = cfg_data[mpps_pkg::NUMER_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) check_word();
            if (s_tvalid && s_tready) predict_event(s_tuser, s_tdata[1:0], s_tdata[17:2]);
        end
        pending <= speed_due.size();
        errors  <= n_err;
        results <= n_res;
    end

endmodule

>>> test/tb_multichannel_pulse_period_speed_top.sv
// Testbench top for the tachometer: drives capture and tick words, config writes, verdict.
module tb_multichannel_pulse_period_speed_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                             SETTLE          = 50;
    localparam int                             ITEMS_PER_PHASE = 250;
    localparam logic [mpps_pkg::CFG_IDX_W-1:0] REG_SPARE       = 2'd3;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [23:0]                     s_tdata   = '0;
    logic                            s_tuser   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [31:0]                     m_tdata;
    logic                            m_tuser;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [mpps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mpps_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    int          pending;
    int          errors;
    int          results;
    bit          calm;
    int          words_sent;
    int          settings_run;
    logic [15:0] recent [4];
    int          rx_left;
    int          rx_pick;
    bit          rx_on;

    multichannel_pulse_period_speed_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tacho_checker tacho_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .errors    (errors),
        .results   (results)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else begin
            if (rx_left <= 0) begin
                rx_pick = $urandom_range(0, 99);
                rx_on   = rx_pick < 60;
                if (rx_pick < 60) rx_left = $urandom_range(1, 20);
                else if (rx_pick < 92) rx_left = $urandom_range(1, 3);
                else rx_left = $urandom_range(10, 60);
            end
            rx_left--;
            m_tready <= rx_on;
        end
    end

    task automatic send_word(input logic op, input logic [1:0] ch, input logic [15:0] cnt);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (calm || r < 60) gap = 0;
        else if (r < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 40);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, cnt, ch};
        do @(posedge aclk); while (!s_tready);
        if (op == mpps_pkg::OP_CAPTURE) recent[ch] = cnt;
        words_sent++;
    endtask

    task automatic rand_item(input int tick_pct);
        logic [1:0]  ch;
        logic [15:0] cnt;
        int          r;
        ch = 2'($urandom_range(0, 3));
        r  = $urandom_range(0, 9);
        if (r < 5) cnt = recent[ch] + 16'($urandom_range(1, 400));
        else if (r < 7) cnt = recent[ch] - 16'($urandom_range(0, 20));
        else cnt = 16'($urandom);
        send_word(($urandom_range(0, 99) < tick_pct) ? mpps_pkg::OP_TICK : mpps_pkg::OP_CAPTURE,
                  ch, cnt);
    endtask

    task automatic run_phase(input int tick_pct, input bit quiet);
        calm = quiet;
        repeat (ITEMS_PER_PHASE) rand_item(tick_pct);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [mpps_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_setting(input logic [31:0] per, input logic [31:0] tmo,
                                 input logic [31:0] num);
        wait_idle();
        write_reg(REG_SPARE, $urandom);
        write_reg(mpps_pkg::REG_PERIOD, per);
        write_reg(mpps_pkg::REG_TIMEOUT, tmo);
        write_reg(mpps_pkg::REG_NUMER, num);
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    initial begin
        #3_000_000;
        $display("tb_multichannel_pulse_period_speed_top failed");
        $finish;
    end

    initial begin
        for (int i = 0; i < 4; i++) recent[i] = '0;
        settings_run = 1;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // default setting: arming, saturation, negative span, overflow span
        send_word(mpps_pkg::OP_TICK,    2'd0, 16'd7);
        send_word(mpps_pkg::OP_CAPTURE, 2'd0, 16'd0);
        send_word(mpps_pkg::OP_CAPTURE, 2'd0, 16'd0);
        send_word(mpps_pkg::OP_CAPTURE, 2'd0, 16'hFFFF);
        send_word(mpps_pkg::OP_CAPTURE, 2'd0, 16'd100);
        send_word(mpps_pkg::OP_TICK,    2'd0, 16'hFFFF);
        send_word(mpps_pkg::OP_CAPTURE, 2'd0, 16'd0);
        send_word(mpps_pkg::OP_CAPTURE, 2'd1, 16'hFFFF);
        send_word(mpps_pkg::OP_CAPTURE, 2'd1, 16'hFFFF);
        send_word(mpps_pkg::OP_CAPTURE, 2'd2, 16'd1000);
        send_word(mpps_pkg::OP_CAPTURE, 2'd2, 16'd1027);
        send_word(mpps_pkg::OP_CAPTURE, 2'd2, 16'd1053);
        send_word(mpps_pkg::OP_CAPTURE, 2'd3, 16'd12345);
        repeat (3) send_word(mpps_pkg::OP_TICK, 2'd3, 16'hAAAA);
        send_word(mpps_pkg::OP_CAPTURE, 2'd3, 16'd0);
        send_word(mpps_pkg::OP_CAPTURE, 2'd3, 16'hFFFF);
        run_phase(30, 1'b0);

        apply_setting(32'h0001_0000, 32'h0000_FFFF, 32'hFFFF_FFFF);
        run_phase(30, 1'b0);

        apply_setting(($urandom & 32'hFFFE_0000) | 32'd1,
                      ($urandom & 32'hFFFF_0000) | 32'd1, 32'd0);
        run_phase(30, 1'b0);

        // zero limit: the first tick on an armed channel times out
        apply_setting($urandom_range(1, 65536), 32'd0, $urandom);
        send_word(mpps_pkg::OP_CAPTURE, 2'd0, 16'd500);
        send_word(mpps_pkg::OP_TICK,    2'd0, 16'd0);
        send_word(mpps_pkg::OP_TICK,    2'd0, 16'd0);
        run_phase(25, 1'b0);

        apply_setting($urandom_range(1, 2000), $urandom_range(2, 12), $urandom);
        run_phase(45, 1'b1);

        apply_setting($urandom_range(1, 65536), $urandom_range(1, 65535), $urandom);
        run_phase(35, 1'b0);

        apply_setting(32'(mpps_pkg::PERIOD_RST), 32'(mpps_pkg::TIMEOUT_RST),
                      32'(mpps_pkg::NUMER_RST));
        run_phase(30, 1'b0);

        wait_idle();
        $display("covered %0d capture/tick words over %0d register settings", words_sent,
                 settings_run);
        $display("checked %0d speed words, %0d failures", results, errors);
        if (errors == 0 && pending == 0) begin
            $display("tb_multichannel_pulse_period_speed_top passed");
        end else begin
            $display("tb_multichannel_pulse_period_speed_top failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/mpps_pkg.sv
src/mpps_div.sv
src/multichannel_pulse_period_speed_top.sv
test/tacho_checker.sv
test/tb_multichannel_pulse_period_speed_top.sv
